/* src/dominant_speaker_window_vote_macros.svh */
// Assertion macros for the dominant speaker window vote block.
`ifndef DOMINANT_SPEAKER_WINDOW_VOTE_MACROS_SVH
`define DOMINANT_SPEAKER_WINDOW_VOTE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DSV_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DSV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/dsv_pkg.sv */
// Package with types and constants of the dominant speaker window vote block.
package dsv_pkg;

    localparam int NUM_STREAMS_DEF = 16;

    localparam int ID_W     = 4;
    localparam int ENERGY_W = 31;
    localparam int WINS_W   = 16;
    localparam int TOTAL_W  = 48;
    localparam int FRAMES_W = 16;
    localparam int CFG_W    = 31;

    localparam logic [ENERGY_W-1:0] WIN_THRESHOLD_RST = 31'd10000000;
    localparam logic [FRAMES_W-1:0] WINDOW_FRAMES_RST = 16'd100;

    localparam logic CFG_WIN_THRESHOLD = 1'b0;
    localparam logic CFG_WINDOW_FRAMES = 1'b1;

    localparam logic FUNC_REPORT    = 1'b0;
    localparam logic FUNC_FRAME_END = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [WINS_W-1:0]  wins;
        logic [TOTAL_W-1:0] total;
    } t_tally;

endpackage

/* src/dominant_speaker_window_vote.sv */
// Top level of the dominant speaker window vote block.
//
// Input stream (s side): tuser carries func (0 energy report, 1 end of frame),
// tdata carries the stream index and energy. Output stream (m side): tdata carries
// the chosen speaker_id, one transfer per decision window that saw any win.
// Config port: write enable, register index (0 win_threshold, 1 window_frames)
// and data; writes take effect at the clock edge. Write only while the block is
// idle; the block itself does not enforce this. Sequencing: an energy report or
// an end of frame without a win is handled in ST_IDLE. An end of frame with a win
// reads the tally memory there and does the saturating add/write in ST_UPD. A
// window close adds a scan, one memory read and one compare per stream, on the
// single tally read port. tready is low while the sequencer is busy.
// Reset: synchronous, active low; registers return to their reset values and
// the tallies read as zero (per-entry valid bits clear at once).
// Stall: the result sits in an output register; new input keeps flowing while
// it waits. Only a second result that finds the register still full holds the
// sequencer until the receiver takes the first one.
`include "dominant_speaker_window_vote_macros.svh"

module dominant_speaker_window_vote #(
    parameter int NUM_STREAMS = dsv_pkg::NUM_STREAMS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_addr,
    input  logic [30:0] i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // [3:0] stream index, [34:4] energy, [39:35] zero
    input  logic [0:0]  i_s_tuser,   // [0] func
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata    // [3:0] speaker_id, [7:4] zero
);

    localparam int IW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_STREAMS - 1);

    dsv_pkg::t_state r_state, n_state;

    logic [dsv_pkg::ENERGY_W-1:0] r_threshold;
    logic [dsv_pkg::FRAMES_W-1:0] r_window;
    logic [dsv_pkg::ENERGY_W-1:0] r_best_energy;
    logic [dsv_pkg::ID_W-1:0]     r_best_stream;
    logic                         r_has_report;
    logic [dsv_pkg::FRAMES_W-1:0] r_frames;
    logic                         r_close;
    logic [IW-1:0]                r_idx;
    logic                         r_found;
    logic [dsv_pkg::WINS_W-1:0]   r_top_wins;
    logic [dsv_pkg::TOTAL_W-1:0]  r_top_total;
    logic [IW-1:0]                r_top_id;
    logic                         r_out_valid;
    logic [dsv_pkg::ID_W-1:0]     r_out_id;
    logic [NUM_STREAMS-1:0]       r_valid;

    dsv_pkg::t_tally mem [NUM_STREAMS];
    dsv_pkg::t_tally r_rd_data;
    logic            r_rd_ok;

    logic                         s_fire;
    logic                         in_func;
    logic [dsv_pkg::ID_W-1:0]     in_sid;
    logic [dsv_pkg::ENERGY_W-1:0] in_energy;
    logic                         sid_ok;
    logic                         is_win;
    logic [dsv_pkg::FRAMES_W-1:0] frames_inc;
    logic                         will_close;

    logic [IW-1:0]         rd_addr;
    logic                  mem_we;
    logic [IW-1:0]         wr_addr;
    dsv_pkg::t_tally       wr_data;
    logic                  clear_frame;
    logic                  scan_start;
    logic                  out_load;
    logic                  tally_clear;

    logic [dsv_pkg::WINS_W-1:0]  cur_wins;
    logic [dsv_pkg::TOTAL_W-1:0] cur_total;
    logic [dsv_pkg::TOTAL_W:0]   sum;
    logic                        take;

    assign in_func   = i_s_tuser[0];
    assign in_sid    = i_s_tdata[3:0];
    assign in_energy = i_s_tdata[34:4];
    assign sid_ok    = 32'(in_sid) < NUM_STREAMS;

    assign o_s_tready = (r_state == dsv_pkg::ST_IDLE);
    assign s_fire     = i_s_tvalid && o_s_tready;

    assign is_win     = r_best_energy > r_threshold;
    assign frames_inc = (r_frames != '1) ? r_frames + 16'd1 : r_frames;
    assign will_close = frames_inc >= r_window;

    assign cur_wins  = r_rd_ok ? r_rd_data.wins : '0;
    assign cur_total = r_rd_ok ? r_rd_data.total : '0;
    assign sum       = {1'b0, cur_total} + 49'(r_best_energy);
    assign take      = (cur_wins != '0) &&
                       (!r_found || (cur_wins > r_top_wins) ||
                        ((cur_wins == r_top_wins) && (cur_total > r_top_total)));

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0, r_out_id};

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dsv_pkg::ST_IDLE: begin
                if (s_fire && (in_func == dsv_pkg::FUNC_FRAME_END) && r_has_report) begin
                    if (is_win) begin
                        n_state = dsv_pkg::ST_UPD;
                    end else if (will_close) begin
                        n_state = dsv_pkg::ST_SCAN_RD;
                    end
                end
            end
            dsv_pkg::ST_UPD: begin
                n_state = r_close ? dsv_pkg::ST_SCAN_RD : dsv_pkg::ST_IDLE;
            end
            dsv_pkg::ST_SCAN_RD: begin
                n_state = dsv_pkg::ST_SCAN_CMP;
            end
            dsv_pkg::ST_SCAN_CMP: begin
                n_state = (r_idx == LAST_IDX) ? dsv_pkg::ST_DONE : dsv_pkg::ST_SCAN_RD;
            end
            dsv_pkg::ST_DONE: begin
                if (!r_found || !r_out_valid || i_m_tready) begin
                    n_state = dsv_pkg::ST_IDLE;
                end
            end
            default: n_state = dsv_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        rd_addr     = r_idx;
        mem_we      = 1'b0;
        wr_addr     = IW'(r_best_stream);
        wr_data.wins  = (cur_wins != '1) ? cur_wins + 16'd1 : cur_wins;
        wr_data.total = sum[dsv_pkg::TOTAL_W] ? '1 : sum[dsv_pkg::TOTAL_W-1:0];
        clear_frame = 1'b0;
        scan_start  = 1'b0;
        out_load    = 1'b0;
        tally_clear = 1'b0;
        unique case (r_state)
            dsv_pkg::ST_IDLE: begin
                rd_addr = IW'(r_best_stream);
                if (s_fire && (in_func == dsv_pkg::FUNC_FRAME_END) && r_has_report) begin
                    clear_frame = !is_win;
                    scan_start  = will_close;
                end
            end
            dsv_pkg::ST_UPD: begin
                mem_we      = 1'b1;
                clear_frame = 1'b1;
            end
            dsv_pkg::ST_SCAN_RD: begin
            end
            dsv_pkg::ST_SCAN_CMP: begin
            end
            dsv_pkg::ST_DONE: begin
                if (!r_found || !r_out_valid || i_m_tready) begin
                    out_load    = r_found;
                    tally_clear = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Tally memory.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= dsv_pkg::ST_IDLE;
            r_threshold   <= dsv_pkg::WIN_THRESHOLD_RST;
            r_window      <= dsv_pkg::WINDOW_FRAMES_RST;
            r_best_energy <= '0;
            r_best_stream <= '0;
            r_has_report  <= 1'b0;
            r_frames      <= '0;
            r_close       <= 1'b0;
            r_idx         <= '0;
            r_found       <= 1'b0;
            r_top_wins    <= '0;
            r_top_total   <= '0;
            r_top_id      <= '0;
            r_out_valid   <= 1'b0;
            r_out_id      <= '0;
            r_valid       <= '0;
            r_rd_ok       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_ok <= r_valid[rd_addr];

            if (i_cfg_wr_en) begin
                unique case (i_cfg_addr)
                    dsv_pkg::CFG_WIN_THRESHOLD: r_threshold <= i_cfg_data;
                    dsv_pkg::CFG_WINDOW_FRAMES: r_window    <= i_cfg_data[15:0];
                    default: begin
                    end
                endcase
            end

            if (s_fire && (in_func == dsv_pkg::FUNC_REPORT) && sid_ok) begin
                r_has_report <= 1'b1;
                if (in_energy > r_best_energy) begin
                    r_best_energy <= in_energy;
                    r_best_stream <= in_sid;
                end
            end

            if (s_fire && (in_func == dsv_pkg::FUNC_FRAME_END) && r_has_report) begin
                r_close  <= will_close;
                r_frames <= will_close ? '0 : frames_inc;
            end

            if (clear_frame) begin
                r_best_energy <= '0;
                r_best_stream <= '0;
                r_has_report  <= 1'b0;
            end

            if (mem_we) begin
                r_valid[wr_addr] <= 1'b1;
            end

            if (scan_start) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end

            if (r_state == dsv_pkg::ST_UPD && r_close) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end

            if (r_state == dsv_pkg::ST_SCAN_CMP) begin
                if (take) begin
                    r_found     <= 1'b1;
                    r_top_wins  <= cur_wins;
                    r_top_total <= cur_total;
                    r_top_id    <= r_idx;
                end
                if (r_idx != LAST_IDX) begin
                    r_idx <= r_idx + 1'b1;
                end
            end

            if (tally_clear) begin
                r_valid <= '0;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
                r_out_id    <= dsv_pkg::ID_W'(r_top_id);
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `DSV_ASSERT_SAME(a_upd_after_frame_end, i_clk, i_rst_n,
        r_state == dsv_pkg::ST_UPD,
        $past(s_fire) && ($past(in_func) == dsv_pkg::FUNC_FRAME_END),
        "tally update without a preceding frame end")
    `DSV_ASSERT_NEXT(a_tally_cleared, i_clk, i_rst_n,
        tally_clear, r_valid == '0,
        "tallies not cleared after window close")
    `DSV_ASSERT_SAME(a_cmp_after_read, i_clk, i_rst_n,
        r_state == dsv_pkg::ST_SCAN_CMP, $past(r_state) == dsv_pkg::ST_SCAN_RD,
        "scan compare without a memory read")
    `DSV_ASSERT_NEXT(a_out_load_free, i_clk, i_rst_n,
        out_load && !(r_out_valid && !i_m_tready), r_out_valid,
        "result lost at output register")

endmodule

/* bench/tb_dominant_speaker_window_vote.sv */
// Testbench for dominant_speaker_window_vote: directed table plus random frames, self-checking.
`timescale 1ns / 1ps

module tb_dominant_speaker_window_vote;

    localparam int NSTR     = dsv_pkg::NUM_STREAMS_DEF;
    localparam int ID_W     = dsv_pkg::ID_W;
    localparam int ENERGY_W = dsv_pkg::ENERGY_W;
    localparam int WINS_W   = dsv_pkg::WINS_W;
    localparam int TOTAL_W  = dsv_pkg::TOTAL_W;
    localparam int FRAMES_W = dsv_pkg::FRAMES_W;
    localparam int CFG_W    = dsv_pkg::CFG_W;

    localparam logic [ENERGY_W-1:0] WIN_THRESHOLD_RST = dsv_pkg::WIN_THRESHOLD_RST;
    localparam logic [FRAMES_W-1:0] WINDOW_FRAMES_RST = dsv_pkg::WINDOW_FRAMES_RST;
    localparam logic CFG_WIN_THRESHOLD = dsv_pkg::CFG_WIN_THRESHOLD;
    localparam logic CFG_WINDOW_FRAMES = dsv_pkg::CFG_WINDOW_FRAMES;
    localparam logic FUNC_REPORT       = dsv_pkg::FUNC_REPORT;
    localparam logic FUNC_FRAME_END    = dsv_pkg::FUNC_FRAME_END;

    localparam int                  CYC_LIMIT = 400000;
    localparam int                  SETTLE    = 2 * NSTR + 48;
    localparam logic [ENERGY_W-1:0] EN_MAX    = '1;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        logic               addr;
        logic               func;
        logic [ID_W-1:0]    sid;
        logic [CFG_W-1:0]   val;
        logic               typed;
        logic [ID_W-1:0]    spk;
    } t_dir_row;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic        i_cfg_addr  = 1'b0;
    logic [30:0] i_cfg_data  = '0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata   = '0;
    logic [0:0]  i_s_tuser   = '0;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [7:0]  o_m_tdata;

    // predicted block state
    logic [CFG_W-1:0]    thr;
    logic [FRAMES_W-1:0] wnd;
    logic [ENERGY_W-1:0] best_en;
    logic [ID_W-1:0]     best_sid;
    logic                has_rep;
    logic [FRAMES_W-1:0] frames;
    logic [WINS_W-1:0]   wins   [NSTR];
    logic [TOTAL_W-1:0]  totals [NSTR];

    logic [ID_W-1:0] speaker_q [$];
    int              err_cnt   = 0;
    int              cyc       = 0;
    int              snd_idle  = 0;
    int              rcv_idle  = 0;
    t_dir_row        dir_tab   [$];

    dominant_speaker_window_vote dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    task automatic flag_error(input string msg);
        $display("mismatch at cycle %0d: %s", cyc, msg);
        err_cnt++;
    endtask

    task automatic clear_tallies();
        for (int s = 0; s < NSTR; s++) begin
            wins[s]   = '0;
            totals[s] = '0;
        end
    endtask

    task automatic predict_vote(input logic func, input logic [ID_W-1:0] sid,
                                input logic [ENERGY_W-1:0] en, output bit got,
                                output logic [ID_W-1:0] who);
        logic [WINS_W-1:0]  bw;
        logic [TOTAL_W-1:0] bt;
        logic [TOTAL_W:0]   sum;
        got = 1'b0;
        who = '0;
        bw  = '0;
        bt  = '0;
        if (func == FUNC_REPORT) begin
            if (sid < NSTR) begin
                has_rep = 1'b1;
                if (en > best_en) begin
                    best_en  = en;
                    best_sid = sid;
                end
            end
        end else if (has_rep) begin
            if (best_en > thr) begin
                if (wins[best_sid] != '1)
                    wins[best_sid]++;
                sum = {1'b0, totals[best_sid]} + best_en;
                totals[best_sid] = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
            end
            best_en  = '0;
            best_sid = '0;
            has_rep  = 1'b0;
            if (frames != '1)
                frames++;
            if (frames >= wnd) begin
                frames = '0;
                for (int s = 0; s < NSTR; s++) begin
                    if (wins[s] != '0) begin
                        if (!got || wins[s] > bw || (wins[s] == bw && totals[s] > bt)) begin
                            bw  = wins[s];
                            bt  = totals[s];
                            who = s[ID_W-1:0];
                        end
                        got = 1'b1;
                    end
                end
                clear_tallies();
            end
        end
    endtask

    task automatic write_reg(input logic addr, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (addr == CFG_WIN_THRESHOLD)
            thr = val;
        else
            wnd = val[FRAMES_W-1:0];
    endtask

    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (speaker_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic push_item(input logic func, input logic [ID_W-1:0] sid,
                             input logic [ENERGY_W-1:0] en, input logic typed,
                             input logic [ID_W-1:0] spk);
        bit              got;
        logic [ID_W-1:0] who;
        if ($urandom_range(99) < snd_idle) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {5'd0, en, sid};
        i_s_tuser  <= func;
        do @(posedge i_clk); while (!o_s_tready);
        predict_vote(func, sid, en, got, who);
        if (typed)
            speaker_q = {speaker_q, spk};
        else if (got)
            speaker_q = {speaker_q, who};
    endtask

    always @(posedge i_clk)
        i_m_tready <= ($urandom_range(99) >= rcv_idle);

    always @(posedge i_clk) begin
        logic [ID_W-1:0] want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (speaker_q.size() == 0) begin
                flag_error($sformatf("speaker %0d with none pending", o_m_tdata[3:0]));
            end else begin
                want = speaker_q.pop_front();
                if (o_m_tdata[3:0] !== want)
                    flag_error($sformatf("speaker_id %0d, want %0d", o_m_tdata[3:0], want));
            end
        end
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc == CYC_LIMIT) begin
            $display("[dominant_speaker_window_vote] ERROR");
            $finish;
        end
    end

    initial begin
        logic [ID_W-1:0]     sid;
        logic [ENERGY_W-1:0] en;
        logic [CFG_W-1:0]    th;
        logic [FRAMES_W-1:0] wf;
        logic [ID_W-1:0]     pool;
        int                  nrep;
        int                  sent;

        thr      = WIN_THRESHOLD_RST;
        wnd      = WINDOW_FRAMES_RST;
        best_en  = '0;
        best_sid = '0;
        has_rep  = 1'b0;
        frames   = '0;
        clear_tallies();

        dir_tab = '{
            '{ROW_CFG,  CFG_WINDOW_FRAMES, FUNC_REPORT,    4'd0,  31'd2,   1'b0, 4'd0},
            '{ROW_CFG,  CFG_WIN_THRESHOLD, FUNC_REPORT,    4'd0,  31'd0,   1'b0, 4'd0},
            '{ROW_ITEM, CFG_WIN_THRESHOLD, FUNC_REPORT,    4'd0,  31'd0,   1'b0, 4'd0},
            '{ROW_ITEM, CFG_WIN_THRESHOLD, FUNC_FRAME_END, 4'd0,  31'd0,   1'b0, 4'd0},
            '{ROW_ITEM, CFG_WIN_THRESHOLD, FUNC_FRAME_END, 4'd0,  31'd0,   1'b0, 4'd0},
            '{ROW_ITEM, CFG_WIN_THRESHOLD, FUNC_REPORT,    4'd15, EN_MAX,  1'b0, 4'd0},
            '{ROW_ITEM, CFG_WIN_THRESHOLD, FUNC_REPORT,    4'd3,  EN_MAX,  1'b0, 4'd0},
            '{ROW_ITEM, CFG_WIN_THRESHOLD, FUNC_FRAME_END, 4'd0,  31'd0,   1'b1, 4'd15},
            '{ROW_CFG,  CFG_WIN_THRESHOLD, FUNC_REPORT,    4'd0,  EN_MAX,  1'b0, 4'd0},
            '{ROW_ITEM, CFG_WIN_THRESHOLD, FUNC_REPORT,    4'd5,  EN_MAX,  1'b0, 4'd0},
            '{ROW_ITEM, CFG_WIN_THRESHOLD, FUNC_FRAME_END, 4'd0,  31'd0,   1'b0, 4'd0},
            '{ROW_ITEM, CFG_WIN_THRESHOLD, FUNC_REPORT,    4'd1,  31'd1,   1'b0, 4'd0},
            '{ROW_ITEM, CFG_WIN_THRESHOLD, FUNC_FRAME_END, 4'd0,  31'd0,   1'b0, 4'd0},
            '{ROW_CFG,  CFG_WIN_THRESHOLD, FUNC_REPORT,    4'd0,  31'd0,   1'b0, 4'd0},
            '{ROW_CFG,  CFG_WINDOW_FRAMES, FUNC_REPORT,    4'd0,  31'd0,   1'b0, 4'd0},
            '{ROW_ITEM, CFG_WIN_THRESHOLD, FUNC_REPORT,    4'd9,  31'd1,   1'b0, 4'd0},
            '{ROW_ITEM, CFG_WIN_THRESHOLD, FUNC_FRAME_END, 4'd0,  31'd0,   1'b1, 4'd9},
            '{ROW_CFG,  CFG_WINDOW_FRAMES, FUNC_REPORT,    4'd0,  31'd3,   1'b0, 4'd0},
            '{ROW_ITEM, CFG_WIN_THRESHOLD, FUNC_REPORT,    4'd2,  31'd100, 1'b0, 4'd0},
            '{ROW_ITEM, CFG_WIN_THRESHOLD, FUNC_FRAME_END, 4'd0,  31'd0,   1'b0, 4'd0},
            '{ROW_ITEM, CFG_WIN_THRESHOLD, FUNC_REPORT,    4'd7,  31'd200, 1'b0, 4'd0},
            '{ROW_ITEM, CFG_WIN_THRESHOLD, FUNC_FRAME_END, 4'd0,  31'd0,   1'b0, 4'd0},
            '{ROW_ITEM, CFG_WIN_THRESHOLD, FUNC_REPORT,    4'd4,  31'd0,   1'b0, 4'd0},
            '{ROW_ITEM, CFG_WIN_THRESHOLD, FUNC_FRAME_END, 4'd0,  31'd0,   1'b1, 4'd7},
            '{ROW_ITEM, CFG_WIN_THRESHOLD, FUNC_REPORT,    4'd6,  31'd300, 1'b0, 4'd0},
            '{ROW_ITEM, CFG_WIN_THRESHOLD, FUNC_FRAME_END, 4'd0,  31'd0,   1'b0, 4'd0},
            '{ROW_ITEM, CFG_WIN_THRESHOLD, FUNC_REPORT,    4'd11, 31'd300, 1'b0, 4'd0},
            '{ROW_ITEM, CFG_WIN_THRESHOLD, FUNC_FRAME_END, 4'd0,  31'd0,   1'b0, 4'd0},
            '{ROW_ITEM, CFG_WIN_THRESHOLD, FUNC_REPORT,    4'd4,  31'd0,   1'b0, 4'd0},
            '{ROW_ITEM, CFG_WIN_THRESHOLD, FUNC_FRAME_END, 4'd0,  31'd0,   1'b1, 4'd6}
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        snd_idle = 28;
        rcv_idle = 61;
        foreach (dir_tab[r]) begin
            if (dir_tab[r].kind == ROW_CFG) begin
                settle();
                write_reg(dir_tab[r].addr, dir_tab[r].val);
            end else if (dir_tab[r].func == FUNC_FRAME_END) begin
                push_item(FUNC_FRAME_END, ID_W'($urandom), ENERGY_W'($urandom),
                          dir_tab[r].typed, dir_tab[r].spk);
            end else begin
                push_item(FUNC_REPORT, dir_tab[r].sid, dir_tab[r].val, dir_tab[r].typed,
                          dir_tab[r].spk);
            end
        end

        for (int ph = 0; ph < 12; ph++) begin
            settle();
            snd_idle = (ph < 4) ? 28 : (ph < 8) ? 61 : 0;
            rcv_idle = (ph < 4) ? 61 : (ph < 8) ? 28 : 0;
            case ($urandom_range(0, 3))
                0:       th = CFG_W'($urandom_range(0, 150));
                1:       th = CFG_W'($urandom);
                2:       th = CFG_W'($urandom_range(0, 1000));
                default: th = 31'h40000000;
            endcase
            wf = FRAMES_W'($urandom_range(1, 8));
            if (ph == 0) th = '0;
            if (ph == 1) th = EN_MAX;
            if (ph == 2) wf = '1;
            if (ph == 3) wf = 16'd2;
            if (ph == 5) wf = '0;
            write_reg(CFG_WIN_THRESHOLD, th);
            write_reg(CFG_WINDOW_FRAMES, {15'($urandom), wf});
            pool = ID_W'($urandom);
            sent = 0;
            while (sent < 135) begin
                nrep = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
                for (int k = 0; k < nrep; k++) begin
                    sid = $urandom_range(0, 1) ? ID_W'(pool + $urandom_range(0, 2))
                                               : ID_W'($urandom);
                    case ($urandom_range(0, 5))
                        0:       en = '0;
                        1:       en = EN_MAX;
                        2:       en = 31'(100 * $urandom_range(1, 3));
                        3:       en = ENERGY_W'($urandom_range(0, 1000));
                        default: en = ENERGY_W'($urandom);
                    endcase
                    push_item(FUNC_REPORT, sid, en, 1'b0, '0);
                    sent++;
                end
                push_item(FUNC_FRAME_END, ID_W'($urandom), ENERGY_W'($urandom), 1'b0, '0);
                sent++;
            end
        end

        settle();
        if (err_cnt == 0) begin
            $display("[dominant_speaker_window_vote] OK");
        end else begin
            $display("[dominant_speaker_window_vote] ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/dsv_pkg.sv
src/dominant_speaker_window_vote.sv
bench/tb_dominant_speaker_window_vote.sv
